>>> hdl/tlc_pkg.sv
// ----------------------------------------------------------------------------
// tlc_pkg
// Types, constants and set-row helper functions for the two-level cache model.
// ----------------------------------------------------------------------------
package tlc_pkg;

  localparam int NEAR_SETS  = 64;
  localparam int FAR_SETS   = 512;
  localparam int WAY_COUNT  = 8;
  localparam int LINE_SHIFT = 6;

  localparam int ADDR_W     = 64;
  localparam int TAG_W      = ADDR_W - LINE_SHIFT;
  localparam int WAY_W      = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
  localparam int NEAR_IDX_W = (NEAR_SETS > 1) ? $clog2(NEAR_SETS) : 1;
  localparam int FAR_IDX_W  = (FAR_SETS > 1) ? $clog2(FAR_SETS) : 1;
  localparam int CNT_W      = 32;
  localparam int CNT_NUM    = 7;

  // Run counter slots.
  localparam int CNT_READS       = 0;
  localparam int CNT_WRITES      = 1;
  localparam int CNT_FIRST_HITS  = 2;
  localparam int CNT_FIRST_MISS  = 3;
  localparam int CNT_SECOND_HITS = 4;
  localparam int CNT_SECOND_MISS = 5;
  localparam int CNT_WRITEBACKS  = 6;

  typedef logic [TAG_W-1:0] tag_t;
  typedef logic [WAY_W-1:0] way_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic              write_req;
    logic              last_in_run;
  } in_item_t;

  typedef struct packed {
    logic       first_level_hit;
    logic       second_level_hit;
    logic [1:0] writebacks_now;
    cnt_t       total_reads;
    cnt_t       total_writes;
    cnt_t       total_first_hits;
    cnt_t       total_first_misses;
    cnt_t       total_second_hits;
    cnt_t       total_second_misses;
    cnt_t       total_writebacks;
  } out_item_t;

  typedef struct packed {
    tag_t [WAY_COUNT-1:0] tags;
    logic [WAY_COUNT-1:0] valid;
    logic [WAY_COUNT-1:0] dirty;
    way_t [WAY_COUNT-1:0] order;
  } set_row_t;

  localparam int ROW_W = $bits(set_row_t);

  typedef struct packed {
    logic hit;
    way_t way;
  } lookup_t;

  typedef struct packed {
    set_row_t row;
    logic     wb;
  } fill_t;

  // Per-access flags handed to the run statistics.
  typedef struct packed {
    logic       wr;
    logic       hit1;
    logic       hit2;
    logic [1:0] wbs;
  } stat_upd_t;

  typedef cnt_t [CNT_NUM-1:0] cnt_vec_t;

  function automatic set_row_t reset_row();
    set_row_t r;
    r = '0;
    for (int i = 0; i < WAY_COUNT; i++) begin
      r.order[i] = way_t'(i);
    end
    return r;
  endfunction

  function automatic lookup_t find_way(set_row_t r, tag_t blk);
    lookup_t l;
    l = '0;
    for (int w = 0; w < WAY_COUNT; w++) begin
      if (!l.hit && r.valid[w] && (r.tags[w] == blk)) begin
        l.hit = 1'b1;
        l.way = way_t'(w);
      end
    end
    return l;
  endfunction

  function automatic logic [WAY_COUNT-1:0][WAY_W-1:0] make_mru(
      logic [WAY_COUNT-1:0][WAY_W-1:0] ord, way_t way);
    logic [WAY_COUNT-1:0][WAY_W-1:0] o;
    int unsigned pos;
    logic found;
    pos = 0;
    found = 1'b0;
    for (int i = 0; i < WAY_COUNT; i++) begin
      if (!found && (ord[i] == way)) begin
        pos = i;
        found = 1'b1;
      end
    end
    for (int i = 0; i < WAY_COUNT; i++) begin
      if (i == 0) begin
        o[i] = way;
      end else if (i <= pos) begin
        o[i] = ord[i-1];
      end else begin
        o[i] = ord[i];
      end
    end
    return o;
  endfunction

  // Lowest invalid way, otherwise the way at the LRU position.
  function automatic way_t pick_victim(set_row_t r);
    way_t v;
    logic found;
    v = r.order[WAY_COUNT-1];
    found = 1'b0;
    for (int w = 0; w < WAY_COUNT; w++) begin
      if (!found && !r.valid[w]) begin
        v = way_t'(w);
        found = 1'b1;
      end
    end
    return v;
  endfunction

  function automatic fill_t fill_row(set_row_t r, tag_t blk, logic dirty);
    fill_t f;
    way_t v;
    v = pick_victim(r);
    f.wb = r.valid[v] & r.dirty[v];
    f.row = r;
    f.row.tags[v] = blk;
    f.row.valid[v] = 1'b1;
    f.row.dirty[v] = dirty;
    f.row.order = make_mru(r.order, v);
    return f;
  endfunction

endpackage

>>> hdl/two_level_lru_cache_model.sv
// ----------------------------------------------------------------------------
// two_level_lru_cache_model
// Two-level 8-way true-LRU write-back cache model with saturating run totals.
// ----------------------------------------------------------------------------
// After reset the block clears its set memories and takes no item while it
// does so. Each set of each level is one row of a synchronous RAM, read and
// written back by a small sequencer that handles one item at a time: a
// first-level hit or a miss with a clean victim passes through the accept,
// lookup and finish steps, and a miss with a dirty victim adds a victim read
// and a victim write step before finish, since the victim's second-level set
// needs its own read and write of the far RAM port.
// A finished result sits in an output register, so the next item is accepted
// while it waits; that item then stalls in its finish step until the result
// is taken.
module two_level_lru_cache_model (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tlc_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tlc_pkg::out_item_t  out_data
);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_LOOK = 3'd2;
  localparam logic [2:0] S_WBRD = 3'd3;
  localparam logic [2:0] S_WB   = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [tlc_pkg::FAR_IDX_W-1:0] clr_cnt_r;
  tlc_pkg::tag_t blk_r, vb_r, vb_nxt;
  logic wr_r, last_r;
  logic hit1_r, hit1_nxt, hit2_r, hit2_nxt;
  logic [1:0] wbs_r, wbs_nxt;
  logic out_valid_r;
  tlc_pkg::out_item_t out_data_r;

  logic near_we, far_we;
  logic [tlc_pkg::NEAR_IDX_W-1:0] near_waddr, near_raddr;
  logic [tlc_pkg::FAR_IDX_W-1:0] far_waddr, far_raddr;
  tlc_pkg::set_row_t near_wrow, far_wrow, near_rd, far_rd;
  logic [tlc_pkg::ROW_W-1:0] near_rdata, far_rdata;

  logic accept, commit;
  tlc_pkg::stat_upd_t upd;
  tlc_pkg::cnt_vec_t cnt_new;
  tlc_pkg::tag_t in_blk;

  assign in_blk   = in_data.address[tlc_pkg::ADDR_W-1:tlc_pkg::LINE_SHIFT];
  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign commit   = (state_r == S_FIN) && (!out_valid_r || out_ready);
  assign near_rd  = tlc_pkg::set_row_t'(near_rdata);
  assign far_rd   = tlc_pkg::set_row_t'(far_rdata);

  always_comb begin
    tlc_pkg::lookup_t nlk, flk, wlk;
    tlc_pkg::fill_t ff, wf;
    tlc_pkg::way_t v1;
    tlc_pkg::set_row_t nrow, frow;
    state_nxt  = state_r;
    hit1_nxt   = hit1_r;
    hit2_nxt   = hit2_r;
    wbs_nxt    = wbs_r;
    vb_nxt     = vb_r;
    near_we    = 1'b0;
    far_we     = 1'b0;
    near_waddr = blk_r[tlc_pkg::NEAR_IDX_W-1:0];
    far_waddr  = blk_r[tlc_pkg::FAR_IDX_W-1:0];
    near_wrow  = tlc_pkg::reset_row();
    far_wrow   = tlc_pkg::reset_row();
    near_raddr = in_blk[tlc_pkg::NEAR_IDX_W-1:0];
    far_raddr  = in_blk[tlc_pkg::FAR_IDX_W-1:0];
    nlk  = tlc_pkg::find_way(near_rd, blk_r);
    flk  = tlc_pkg::find_way(far_rd, blk_r);
    wlk  = tlc_pkg::find_way(far_rd, vb_r);
    ff   = tlc_pkg::fill_row(far_rd, blk_r, 1'b0);
    wf   = tlc_pkg::fill_row(far_rd, vb_r, 1'b1);
    v1   = tlc_pkg::pick_victim(near_rd);
    nrow = near_rd;
    frow = far_rd;
    unique case (state_r)
      S_CLR: begin
        near_we    = 1'b1;
        far_we     = 1'b1;
        near_waddr = clr_cnt_r[tlc_pkg::NEAR_IDX_W-1:0];
        far_waddr  = clr_cnt_r;
        if (clr_cnt_r == tlc_pkg::FAR_IDX_W'(tlc_pkg::FAR_SETS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        near_we = 1'b1;
        if (nlk.hit) begin
          nrow.order = tlc_pkg::make_mru(near_rd.order, nlk.way);
          if (wr_r) begin
            nrow.dirty[nlk.way] = 1'b1;
          end
          hit1_nxt  = 1'b1;
          hit2_nxt  = 1'b0;
          wbs_nxt   = 2'd0;
          state_nxt = S_FIN;
        end else begin
          far_we = 1'b1;
          if (flk.hit) begin
            frow.order = tlc_pkg::make_mru(far_rd.order, flk.way);
            wbs_nxt    = 2'd0;
          end else begin
            frow    = ff.row;
            wbs_nxt = {1'b0, ff.wb};
          end
          hit1_nxt = 1'b0;
          hit2_nxt = flk.hit;
          vb_nxt   = near_rd.tags[v1];
          nrow.tags[v1]  = blk_r;
          nrow.valid[v1] = 1'b1;
          nrow.dirty[v1] = wr_r;
          nrow.order     = tlc_pkg::make_mru(near_rd.order, v1);
          // A dirty victim must be written into its own far set next.
          state_nxt = (near_rd.valid[v1] && near_rd.dirty[v1]) ? S_WBRD : S_FIN;
        end
        near_wrow = nrow;
        far_wrow  = frow;
      end
      S_WBRD: begin
        far_raddr = vb_r[tlc_pkg::FAR_IDX_W-1:0];
        state_nxt = S_WB;
      end
      S_WB: begin
        far_we    = 1'b1;
        far_waddr = vb_r[tlc_pkg::FAR_IDX_W-1:0];
        if (wlk.hit) begin
          frow.dirty[wlk.way] = 1'b1;
        end else begin
          frow    = wf.row;
          wbs_nxt = wbs_r + {1'b0, wf.wb};
        end
        far_wrow  = frow;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (commit) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      blk_r  <= in_blk;
      wr_r   <= in_data.write_req;
      last_r <= in_data.last_in_run;
    end
    hit1_r <= hit1_nxt;
    hit2_r <= hit2_nxt;
    wbs_r  <= wbs_nxt;
    vb_r   <= vb_nxt;
    if (commit) begin
      out_data_r.first_level_hit     <= hit1_r;
      out_data_r.second_level_hit    <= hit2_r;
      out_data_r.writebacks_now      <= wbs_r;
      out_data_r.total_reads         <= cnt_new[tlc_pkg::CNT_READS];
      out_data_r.total_writes        <= cnt_new[tlc_pkg::CNT_WRITES];
      out_data_r.total_first_hits    <= cnt_new[tlc_pkg::CNT_FIRST_HITS];
      out_data_r.total_first_misses  <= cnt_new[tlc_pkg::CNT_FIRST_MISS];
      out_data_r.total_second_hits   <= cnt_new[tlc_pkg::CNT_SECOND_HITS];
      out_data_r.total_second_misses <= cnt_new[tlc_pkg::CNT_SECOND_MISS];
      out_data_r.total_writebacks    <= cnt_new[tlc_pkg::CNT_WRITEBACKS];
    end
  end

  assign upd.wr   = wr_r;
  assign upd.hit1 = hit1_r;
  assign upd.hit2 = hit2_r;
  assign upd.wbs  = wbs_r;

  tlc_stats u_stats (
    .clk     (clk),
    .rst_n   (rst_n),
    .commit  (commit),
    .last    (last_r),
    .upd     (upd),
    .cnt_new (cnt_new)
  );

  tlc_ram #(.DEPTH(tlc_pkg::NEAR_SETS), .WIDTH(tlc_pkg::ROW_W)) u_near_ram (
    .clk   (clk),
    .we    (near_we),
    .waddr (near_waddr),
    .wdata (near_wrow),
    .raddr (near_raddr),
    .rdata (near_rdata)
  );

  tlc_ram #(.DEPTH(tlc_pkg::FAR_SETS), .WIDTH(tlc_pkg::ROW_W)) u_far_ram (
    .clk   (clk),
    .we    (far_we),
    .waddr (far_waddr),
    .wdata (far_wrow),
    .raddr (far_raddr),
    .rdata (far_rdata)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_no_item_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> !in_ready)
    else $error("item taken during clearing pass");

  a_accept_to_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_LOOK))
    else $error("accepted item did not start a lookup");

  a_hit_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.first_level_hit &&
                    (out_data.second_level_hit || (out_data.writebacks_now != 2'd0))))
    else $error("first-level hit reported with miss-path activity");

  a_commit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !commit)
    else $error("result overwrote a pending item");

endmodule

>>> hdl/tlc_ram.sv
// ----------------------------------------------------------------------------
// tlc_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tlc_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/tlc_stats.sv
// ----------------------------------------------------------------------------
// tlc_stats
// Saturating run totals, updated once per item and cleared after a last item.
// ----------------------------------------------------------------------------
module tlc_stats (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                commit,
  input  logic                last,
  input  tlc_pkg::stat_upd_t  upd,
  output tlc_pkg::cnt_vec_t   cnt_new
);

  tlc_pkg::cnt_vec_t cnt_r;
  logic [tlc_pkg::CNT_NUM-1:0][1:0] inc;

  always_comb begin
    inc = '0;
    inc[tlc_pkg::CNT_READS]       = {1'b0, ~upd.wr};
    inc[tlc_pkg::CNT_WRITES]      = {1'b0, upd.wr};
    inc[tlc_pkg::CNT_FIRST_HITS]  = {1'b0, upd.hit1};
    inc[tlc_pkg::CNT_FIRST_MISS]  = {1'b0, ~upd.hit1};
    inc[tlc_pkg::CNT_SECOND_HITS] = {1'b0, ~upd.hit1 & upd.hit2};
    inc[tlc_pkg::CNT_SECOND_MISS] = {1'b0, ~upd.hit1 & ~upd.hit2};
    inc[tlc_pkg::CNT_WRITEBACKS]  = upd.wbs;
  end

  always_comb begin
    logic [tlc_pkg::CNT_W:0] sum;
    for (int i = 0; i < tlc_pkg::CNT_NUM; i++) begin
      sum = {1'b0, cnt_r[i]} + {{(tlc_pkg::CNT_W-1){1'b0}}, inc[i]};
      cnt_new[i] = sum[tlc_pkg::CNT_W] ? '1 : sum[tlc_pkg::CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (commit) begin
      cnt_r <= last ? '0 : cnt_new;
    end
  end

endmodule

>>> tb/sv/two_level_lru_cache_model_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_level_lru_cache_model_tb
// Drives memory accesses into the two-level cache model and compares every
// result with a behavioral copy of both cache levels and the run totals.
// ----------------------------------------------------------------------------
module two_level_lru_cache_model_tb;

  localparam int RANDOM_ITEMS = 1750;
  localparam int IDLE_LIMIT   = 20000;

  typedef struct {
    tlc_pkg::tag_t tags [tlc_pkg::WAY_COUNT];
    logic [tlc_pkg::WAY_COUNT-1:0] valid;
    logic [tlc_pkg::WAY_COUNT-1:0] dirty;
    int order [tlc_pkg::WAY_COUNT];
  } cache_set_t;

  typedef struct {
    tlc_pkg::in_item_t  acc;
    logic               known;
    tlc_pkg::out_item_t res;
  } access_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  tlc_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  tlc_pkg::out_item_t out_data;

  cache_set_t near_sets [tlc_pkg::NEAR_SETS];
  cache_set_t far_sets [tlc_pkg::FAR_SETS];
  tlc_pkg::cnt_t run_totals [tlc_pkg::CNT_NUM];
  tlc_pkg::out_item_t pending_results [$];
  access_row_t access_table [$];
  int errors = 0;
  int idle_cycles = 0;
  logic stim_done = 1'b0;
  tlc_pkg::tag_t hot_blocks [16];

  two_level_lru_cache_model DUT (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic void clear_cache();
    for (int s = 0; s < tlc_pkg::NEAR_SETS; s++) begin
      near_sets[s].valid = '0;
      near_sets[s].dirty = '0;
      for (int w = 0; w < tlc_pkg::WAY_COUNT; w++) begin
        near_sets[s].tags[w] = '0;
        near_sets[s].order[w] = w;
      end
    end
    for (int s = 0; s < tlc_pkg::FAR_SETS; s++) begin
      far_sets[s].valid = '0;
      far_sets[s].dirty = '0;
      for (int w = 0; w < tlc_pkg::WAY_COUNT; w++) begin
        far_sets[s].tags[w] = '0;
        far_sets[s].order[w] = w;
      end
    end
    for (int i = 0; i < tlc_pkg::CNT_NUM; i++) run_totals[i] = '0;
  endfunction

  function automatic int find_block(cache_set_t cs, tlc_pkg::tag_t blk);
    for (int w = 0; w < tlc_pkg::WAY_COUNT; w++) begin
      if (cs.valid[w] && cs.tags[w] == blk) return w;
    end
    return -1;
  endfunction

  function automatic void touch(ref cache_set_t cs, input int way);
    int pos;
    pos = 0;
    for (int i = 0; i < tlc_pkg::WAY_COUNT; i++) begin
      if (cs.order[i] == way) begin
        pos = i;
        break;
      end
    end
    for (int i = pos; i > 0; i--) cs.order[i] = cs.order[i-1];
    cs.order[0] = way;
  endfunction

  function automatic int choose_way(cache_set_t cs);
    for (int w = 0; w < tlc_pkg::WAY_COUNT; w++) begin
      if (!cs.valid[w]) return w;
    end
    return cs.order[tlc_pkg::WAY_COUNT-1];
  endfunction

  function automatic void bump(input int idx);
    if (run_totals[idx] != '1) run_totals[idx]++;
  endfunction

  // Allocates a block in the far level and returns 1 when a dirty line leaves.
  function automatic int far_allocate(tlc_pkg::tag_t blk, logic dirty);
    int s, v, wb;
    s = int'(blk % tlc_pkg::FAR_SETS);
    v = choose_way(far_sets[s]);
    wb = (far_sets[s].valid[v] && far_sets[s].dirty[v]) ? 1 : 0;
    far_sets[s].tags[v] = blk;
    far_sets[s].valid[v] = 1'b1;
    far_sets[s].dirty[v] = dirty;
    touch(far_sets[s], v);
    return wb;
  endfunction

  function automatic tlc_pkg::out_item_t cache_access(tlc_pkg::in_item_t acc);
    tlc_pkg::out_item_t r;
    tlc_pkg::tag_t blk, vb;
    int s1, s2, sv, w1, w2, wv, v1, wbs;
    r = '0;
    wbs = 0;
    blk = acc.address[tlc_pkg::ADDR_W-1:tlc_pkg::LINE_SHIFT];
    s1 = int'(blk % tlc_pkg::NEAR_SETS);
    bump(acc.write_req ? tlc_pkg::CNT_WRITES : tlc_pkg::CNT_READS);
    w1 = find_block(near_sets[s1], blk);
    if (w1 >= 0) begin
      r.first_level_hit = 1'b1;
      bump(tlc_pkg::CNT_FIRST_HITS);
      touch(near_sets[s1], w1);
      if (acc.write_req) near_sets[s1].dirty[w1] = 1'b1;
    end else begin
      bump(tlc_pkg::CNT_FIRST_MISS);
      s2 = int'(blk % tlc_pkg::FAR_SETS);
      w2 = find_block(far_sets[s2], blk);
      if (w2 >= 0) begin
        r.second_level_hit = 1'b1;
        bump(tlc_pkg::CNT_SECOND_HITS);
        touch(far_sets[s2], w2);
      end else begin
        bump(tlc_pkg::CNT_SECOND_MISS);
        wbs += far_allocate(blk, 1'b0);
      end
      v1 = choose_way(near_sets[s1]);
      if (near_sets[s1].valid[v1] && near_sets[s1].dirty[v1]) begin
        vb = near_sets[s1].tags[v1];
        sv = int'(vb % tlc_pkg::FAR_SETS);
        wv = find_block(far_sets[sv], vb);
        if (wv >= 0) far_sets[sv].dirty[wv] = 1'b1;
        else wbs += far_allocate(vb, 1'b1);
      end
      near_sets[s1].tags[v1] = blk;
      near_sets[s1].valid[v1] = 1'b1;
      near_sets[s1].dirty[v1] = acc.write_req;
      touch(near_sets[s1], v1);
    end
    for (int i = 0; i < wbs; i++) bump(tlc_pkg::CNT_WRITEBACKS);
    r.writebacks_now = wbs[1:0];
    r.total_reads = run_totals[tlc_pkg::CNT_READS];
    r.total_writes = run_totals[tlc_pkg::CNT_WRITES];
    r.total_first_hits = run_totals[tlc_pkg::CNT_FIRST_HITS];
    r.total_first_misses = run_totals[tlc_pkg::CNT_FIRST_MISS];
    r.total_second_hits = run_totals[tlc_pkg::CNT_SECOND_HITS];
    r.total_second_misses = run_totals[tlc_pkg::CNT_SECOND_MISS];
    r.total_writebacks = run_totals[tlc_pkg::CNT_WRITEBACKS];
    if (acc.last_in_run) begin
      for (int i = 0; i < tlc_pkg::CNT_NUM; i++) run_totals[i] = '0;
    end
    return r;
  endfunction

  function automatic int gap_length();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  // Mostly small random gaps, with stretches of full throughput. Valid only
  // drops when a gap follows, so back-to-back items keep it high.
  task automatic send_access(input tlc_pkg::in_item_t acc);
    int gap;
    gap = gap_length();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= acc;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic tlc_pkg::in_item_t make_access(logic [63:0] addr, logic wr, logic last);
    tlc_pkg::in_item_t a;
    a.address = addr;
    a.write_req = wr;
    a.last_in_run = last;
    return a;
  endfunction

  function automatic void add_row(tlc_pkg::in_item_t acc, logic known,
                                  tlc_pkg::out_item_t res);
    access_row_t row;
    row.acc = acc;
    row.known = known;
    row.res = res;
    access_table.push_back(row);
  endfunction

  function automatic void build_directed();
    tlc_pkg::out_item_t first_miss;
    first_miss = '0;
    first_miss.total_reads = 1;
    first_miss.total_first_misses = 1;
    first_miss.total_second_misses = 1;
    add_row(make_access(64'h0, 1'b0, 1'b0), 1'b1, first_miss);
    add_row(make_access(64'h3f, 1'b1, 1'b0), 1'b0, '0);
    add_row(make_access('1, 1'b1, 1'b0), 1'b0, '0);
    add_row(make_access('1, 1'b0, 1'b1), 1'b0, '0);
    add_row(make_access(64'h8000_0000_0000_0000, 1'b1, 1'b0), 1'b0, '0);
    add_row(make_access(64'h5555_5555_5555_5555, 1'b0, 1'b0), 1'b0, '0);
    add_row(make_access(64'haaaa_aaaa_aaaa_aaaa, 1'b1, 1'b0), 1'b0, '0);
    // Nine dirty blocks in one near set, all in one far set: forces LRU
    // eviction of a dirty line whose far set was just refilled.
    for (int i = 1; i <= 9; i++) begin
      add_row(make_access(64'(i) << (tlc_pkg::LINE_SHIFT + 9), 1'b1, 1'b0), 1'b0, '0);
    end
    for (int i = 1; i <= 9; i++) begin
      add_row(make_access(64'(i + 9) << (tlc_pkg::LINE_SHIFT + 9), 1'b1, i == 9), 1'b0, '0);
    end
  endfunction

  function automatic tlc_pkg::in_item_t random_access();
    logic [63:0] addr;
    int kind;
    kind = $urandom_range(0, 9);
    if (kind < 6) begin
      // Reuse of a small working set, aliasing on both levels.
      addr = {hot_blocks[$urandom_range(0, 15)][tlc_pkg::TAG_W-1:12],
              12'($urandom_range(0, 7) * 512 + $urandom_range(0, 3)), 6'($urandom)};
    end else if (kind < 9) begin
      addr = {40'($urandom_range(0, 3)), 18'($urandom), 6'($urandom)};
    end else begin
      addr = {$urandom, $urandom};
    end
    return make_access(addr, 1'($urandom_range(0, 1)), $urandom_range(0, 99) == 0);
  endfunction

  initial begin
    clear_cache();
    for (int i = 0; i < 16; i++) hot_blocks[i] = tlc_pkg::TAG_W'({$urandom, $urandom});
    build_directed();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    foreach (access_table[i]) begin
      tlc_pkg::out_item_t want;
      want = cache_access(access_table[i].acc);
      if (access_table[i].known && want != access_table[i].res) begin
        report("directed table row", i, 0);
      end
      pending_results.push_back(access_table[i].known ? access_table[i].res : want);
      send_access(access_table[i].acc);
    end
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      tlc_pkg::in_item_t acc;
      acc = random_access();
      pending_results.push_back(cache_access(acc));
      send_access(acc);
    end
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    stim_done <= 1'b1;
  end

  // Receiver back pressure.
  initial begin
    int stall;
    forever begin
      @(negedge clk);
      out_ready <= 1'b1;
      stall = gap_length();
      if (stall != 0) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report("unexpected result", 1, 0);
      end else begin
        tlc_pkg::out_item_t want;
        want = pending_results.pop_front();
        if (out_data.first_level_hit !== want.first_level_hit)
          report("first_level_hit", out_data.first_level_hit, want.first_level_hit);
        if (out_data.second_level_hit !== want.second_level_hit)
          report("second_level_hit", out_data.second_level_hit, want.second_level_hit);
        if (out_data.writebacks_now !== want.writebacks_now)
          report("writebacks_now", out_data.writebacks_now, want.writebacks_now);
        if (out_data.total_reads !== want.total_reads)
          report("total_reads", out_data.total_reads, want.total_reads);
        if (out_data.total_writes !== want.total_writes)
          report("total_writes", out_data.total_writes, want.total_writes);
        if (out_data.total_first_hits !== want.total_first_hits)
          report("total_first_hits", out_data.total_first_hits, want.total_first_hits);
        if (out_data.total_first_misses !== want.total_first_misses)
          report("total_first_misses", out_data.total_first_misses, want.total_first_misses);
        if (out_data.total_second_hits !== want.total_second_hits)
          report("total_second_hits", out_data.total_second_hits, want.total_second_hits);
        if (out_data.total_second_misses !== want.total_second_misses)
          report("total_second_misses", out_data.total_second_misses,
                 want.total_second_misses);
        if (out_data.total_writebacks !== want.total_writebacks)
          report("total_writebacks", out_data.total_writebacks, want.total_writebacks);
      end
    end
  end

  // Watchdog: cycles with no accepted item on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("two_level_lru_cache_model verification failed");
      $finish;
    end else if (stim_done) begin
      if (errors == 0 && pending_results.size() == 0) begin
        $display("two_level_lru_cache_model verification clean");
      end else begin
        $display("two_level_lru_cache_model verification failed");
      end
      $finish;
    end
  end

endmodule
